FILE: design/arrc_pkg.sv
// Shared types and sizing constants for the address range reservation checker.
// No dependencies; imported by address_range_reservation_checker.
package arrc_pkg;

    // Table depth and field widths
    localparam int MAX_RANGES = 64;
    localparam int ADDR_BITS  = 48;
    localparam int OWNER_BITS = 16;
    localparam int PERM_BITS  = 5;
    localparam int LEN_BITS   = ADDR_BITS + 1;
    localparam int END_BITS   = ADDR_BITS + 2;
    localparam int IDX_BITS   = $clog2(MAX_RANGES);
    localparam int CNT_BITS   = $clog2(MAX_RANGES + 1);

    // Command codes
    typedef enum logic [1:0] {
        CMD_RESERVE       = 2'd0,
        CMD_UNRESERVE     = 2'd1,
        CMD_UNRESERVE_ALL = 2'd2,
        CMD_CHECK         = 2'd3
    } t_cmd;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_OVERLAP      = 3'd1,
        ST_NOT_RESERVED = 3'd2,
        ST_LEN_MISMATCH = 3'd3,
        ST_FULL         = 3'd4
    } t_status;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_APPLY = 4'b1000
    } t_state;

    // One table entry as held in the range memory
    typedef struct packed {
        logic [ADDR_BITS-1:0]  start;
        logic [LEN_BITS-1:0]   length;
        logic [OWNER_BITS-1:0] owner;
        logic [PERM_BITS-1:0]  perm;
    } t_entry;

endpackage

FILE: design/address_range_reservation_checker.sv
// An accepted item is handled over the single read port: S_SCAN reads the
// table memory one entry per cycle (MAX_RANGES reads), S_DRAIN takes the last
// registered read, and S_APPLY commits the result, waiting while o_valid is
// stalled. o_stall holds off further items until the return to S_IDLE.
// A new item is taken while the previous result still waits on o_valid.
// Reset (synchronous, active low) empties the table and zeroes total and count.
// Range storage and table-wide scan sequencer; depends on arrc_pkg.
module address_range_reservation_checker
    import arrc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_command,
    input  logic [ADDR_BITS-1:0]  i_address,
    input  logic [LEN_BITS-1:0]   i_length,
    input  logic [OWNER_BITS-1:0] i_owner_id,
    input  logic [PERM_BITS-1:0]  i_permission_bits,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_status,
    output logic                  o_allowed,
    output logic [LEN_BITS-1:0]   o_reserved_total,
    output logic [CNT_BITS-1:0]   o_range_count
);

    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(MAX_RANGES - 1);

    // Control state
    t_state                r_state, n_state;
    logic [IDX_BITS-1:0]   r_idx, n_idx;
    logic                  r_pv, n_pv;
    logic [MAX_RANGES-1:0] r_valid, n_valid;
    logic [LEN_BITS-1:0]   r_total, n_total;
    logic [CNT_BITS-1:0]   r_count, n_count;
    logic                  r_clash, n_clash;
    logic                  r_free_found, n_free_found;
    logic                  r_hit_found, n_hit_found;
    logic                  r_best_found, n_best_found;
    logic                  r_out_valid, n_out_valid;

    // Item and scan payload
    t_cmd                  r_cmd;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [LEN_BITS-1:0]   r_len;
    logic [END_BITS-1:0]   r_end;
    logic [OWNER_BITS-1:0] r_owner;
    logic [PERM_BITS-1:0]  r_perm;
    logic [IDX_BITS-1:0]   r_pidx;
    logic                  r_pvalid;
    t_entry                r_rd;
    t_entry                r_mem [MAX_RANGES];
    logic [IDX_BITS-1:0]   r_free;
    logic [IDX_BITS-1:0]   r_hit;
    logic [LEN_BITS-1:0]   r_hit_len;
    logic [ADDR_BITS-1:0]  r_best_start;
    logic [END_BITS-1:0]   r_best_end;
    logic [PERM_BITS-1:0]  r_best_perm;
    t_status               r_out_status;
    logic                  r_out_allowed;
    logic [LEN_BITS-1:0]   r_out_total;
    logic [CNT_BITS-1:0]   r_out_count;

    logic                  accept_in;
    logic                  apply_go;
    logic                  issue;
    logic                  mem_we;
    logic [END_BITS-1:0]   ent_end;
    logic                  free_upd;
    logic                  hit_upd;
    logic                  best_upd;
    logic                  drop_upd;
    t_status               n_status;
    logic                  n_allowed;

    assign o_stall   = (r_state != S_IDLE);
    assign accept_in = i_valid && !o_stall;
    assign issue     = (r_state == S_SCAN);
    assign apply_go  = (r_state == S_APPLY) && !(r_out_valid && i_stall);

    // Shared entry evaluator: one end-address adder and its compares
    assign ent_end = END_BITS'(r_rd.start) + END_BITS'(r_rd.length);

    always_comb begin
        free_upd = 1'b0;
        hit_upd  = 1'b0;
        best_upd = 1'b0;
        drop_upd = 1'b0;
        n_clash  = r_clash;
        if (r_pv) begin
            unique case (r_cmd)
                CMD_RESERVE: begin
                    if (r_pvalid) begin
                        if ((END_BITS'(r_addr) < ent_end) &&
                            (END_BITS'(r_rd.start) < r_end)) begin
                            n_clash = 1'b1;
                        end
                    end else begin
                        free_upd = !r_free_found;
                    end
                end
                CMD_UNRESERVE: begin
                    hit_upd = r_pvalid && (r_rd.start == r_addr);
                end
                CMD_UNRESERVE_ALL: begin
                    drop_upd = r_pvalid && (r_rd.owner == r_owner);
                end
                CMD_CHECK: begin
                    best_upd = r_pvalid && (r_rd.start <= r_addr) &&
                               (!r_best_found || (r_rd.start > r_best_start));
                end
            endcase
        end
        // A new item starts with no overlap seen
        if (accept_in) begin
            n_clash = 1'b0;
        end
    end

    // Sequencer, table bookkeeping and result selection
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pv         = issue;
        n_valid      = r_valid;
        n_total      = r_total;
        n_count      = r_count;
        n_free_found = r_free_found || free_upd;
        n_hit_found  = r_hit_found || hit_upd;
        n_best_found = r_best_found || best_upd;
        n_out_valid  = r_out_valid;
        n_status     = ST_OK;
        n_allowed    = 1'b0;
        mem_we       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                n_idx = r_idx + IDX_BITS'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
        endcase

        // Owner sweep removes entries as they stream past
        if (drop_upd) begin
            n_valid[r_pidx] = 1'b0;
            n_total         = r_total - r_rd.length;
            n_count         = r_count - CNT_BITS'(1);
        end

        // Commit step
        if (r_state == S_APPLY) begin
            unique case (r_cmd)
                CMD_RESERVE: begin
                    if (r_len != '0) begin
                        if (r_clash) begin
                            n_status = ST_OVERLAP;
                        end else if (!r_free_found) begin
                            n_status = ST_FULL;
                        end else if (apply_go) begin
                            mem_we          = 1'b1;
                            n_valid[r_free] = 1'b1;
                            n_total         = r_total + r_len;
                            n_count         = r_count + CNT_BITS'(1);
                        end
                    end
                end
                CMD_UNRESERVE: begin
                    if (!r_hit_found) begin
                        n_status = ST_NOT_RESERVED;
                    end else if (r_hit_len != r_len) begin
                        n_status = ST_LEN_MISMATCH;
                    end else if (apply_go) begin
                        n_valid[r_hit] = 1'b0;
                        n_total        = r_total - r_hit_len;
                        n_count        = r_count - CNT_BITS'(1);
                    end
                end
                CMD_UNRESERVE_ALL: begin
                    n_status = ST_OK;
                end
                CMD_CHECK: begin
                    n_allowed = r_best_found && (r_end <= r_best_end) &&
                                ((r_best_perm & r_perm) == r_perm);
                end
            endcase
        end

        // Clear scan flags for a new item
        if (accept_in) begin
            n_free_found = 1'b0;
            n_hit_found  = 1'b0;
            n_best_found = 1'b0;
        end

        // Output register handshake
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        if (apply_go) begin
            n_out_valid = 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_idx        <= '0;
            r_pv         <= 1'b0;
            r_valid      <= '0;
            r_total      <= '0;
            r_count      <= '0;
            r_clash      <= 1'b0;
            r_free_found <= 1'b0;
            r_hit_found  <= 1'b0;
            r_best_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pv         <= n_pv;
            r_valid      <= n_valid;
            r_total      <= n_total;
            r_count      <= n_count;
            r_clash      <= n_clash;
            r_free_found <= n_free_found;
            r_hit_found  <= n_hit_found;
            r_best_found <= n_best_found;
            r_out_valid  <= n_out_valid;
        end
    end

    // Item capture, memory port and scan payload
    always_ff @(posedge i_clk) begin
        if (accept_in) begin
            r_cmd   <= t_cmd'(i_command);
            r_addr  <= i_address;
            r_len   <= i_length;
            r_end   <= END_BITS'(i_address) + END_BITS'(i_length);
            r_owner <= i_owner_id;
            r_perm  <= i_permission_bits;
        end
        if (issue) begin
            r_rd     <= r_mem[r_idx];
            r_pidx   <= r_idx;
            r_pvalid <= r_valid[r_idx];
        end
        if (mem_we) begin
            r_mem[r_free] <= '{start: r_addr, length: r_len, owner: r_owner, perm: r_perm};
        end
        if (free_upd) begin
            r_free <= r_pidx;
        end
        if (hit_upd) begin
            r_hit     <= r_pidx;
            r_hit_len <= r_rd.length;
        end
        if (best_upd) begin
            r_best_start <= r_rd.start;
            r_best_end   <= ent_end;
            r_best_perm  <= r_rd.perm;
        end
        if (apply_go) begin
            r_out_status  <= n_status;
            r_out_allowed <= n_allowed;
            r_out_total   <= n_total;
            r_out_count   <= n_count;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_allowed        = r_out_allowed;
    assign o_reserved_total = r_out_total;
    assign o_range_count    = r_out_count;

    // Range count tracks the valid bits
    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CNT_BITS'($countones(r_valid)))
        else $error("range count differs from valid entries");

    // Count never exceeds the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(MAX_RANGES))
        else $error("range count above table depth");

    // An accepted item starts a scan
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept_in |=> (r_state == S_SCAN) && (r_idx == '0))
        else $error("accepted item did not start scan");

    // Commit always produces a result
    a_commit_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        apply_go |=> o_valid && (r_state == S_IDLE))
        else $error("commit without result");

endmodule
